// ===== src/lru_key_tracker_defines.svh =====
// Assertion macros for the key tracker.
`ifndef LRU_KEY_TRACKER_DEFINES_SVH
`define LRU_KEY_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define LKT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define LKT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LKT_ASSERT(label, clk, rst, prop, msg)
`define LKT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== src/lkt_pkg.sv =====
`default_nettype none

package lkt_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_WIDTH = 32;
   // Width of the capacity register as written on the configuration port.
   localparam int CFG_W     = 5;
   // Width that holds a slot count from 0 to ENTRIES.
   localparam int CAP_W     = $clog2(ENTRIES + 1);
   localparam int CAP_RESET = (16 > ENTRIES) ? ENTRIES : 16;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic                 fire;
      logic [KEY_WIDTH-1:0] key;
      logic                 hit;
      logic [CAP_W-1:0]     cap;
      logic                 cfg_write;
      logic [CAP_W-1:0]     cfg_cap;
   } ctl_type;

   // Travels from the least recent end toward slot 0.
   typedef struct packed {
      logic                 any_match;
      logic                 tail_valid;
      logic [KEY_WIDTH-1:0] tail_key;
   } up_type;

   // Travels from slot 0 toward the least recent end.
   typedef struct packed {
      logic                 valid;
      logic [KEY_WIDTH-1:0] key;
   } down_type;

endpackage

`default_nettype wire

// ===== src/lkt_cell.sv =====
`default_nettype none

module lkt_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [lkt_pkg::CAP_W-1:0] slot,
   input  wire lkt_pkg::ctl_type      ctl,
   input  wire lkt_pkg::down_type     down_in,
   output lkt_pkg::down_type          down_out,
   input  wire lkt_pkg::up_type       up_in,
   output lkt_pkg::up_type            up_out
);

   logic [lkt_pkg::KEY_WIDTH-1:0] key_ff;
   logic                          valid_ff;
   logic                          valid_in;
   logic                          match;
   logic                          last;
   logic                          shift;

   assign match = valid_ff && (key_ff == ctl.key);
   // This slot is the least recent one the capacity allows.
   assign last  = (slot + lkt_pkg::CAP_W'(1)) == ctl.cap;

   assign up_out.any_match  = up_in.any_match | match;
   assign up_out.tail_valid = up_in.tail_valid | (last & valid_ff);
   assign up_out.tail_key   = up_in.tail_key | ((last && valid_ff) ? key_ff : '0);

   assign down_out.valid = valid_ff;
   assign down_out.key   = key_ff;

   // On a hit, slots down to the matching one advance; on a miss, every slot
   // up to the first empty one advances, bounded by the capacity.
   assign shift = ctl.hit ? up_out.any_match : (down_in.valid && (slot < ctl.cap));

   always_comb begin
      valid_in = valid_ff;
      if (ctl.fire && shift) begin
         valid_in = down_in.valid;
      end
      // Drop entries beyond a lowered capacity.
      if (ctl.cfg_write && !(slot < ctl.cfg_cap)) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire && shift) begin
         key_ff <= down_in.key;
      end
   end

endmodule

`default_nettype wire

// ===== src/lru_key_tracker.sv =====
// Fully associative LRU key tracker.
// Request channel (req_valid / req_stall, req_key): one key per beat. The
// key is looked up in every slot at once and the recency row is updated in
// the cycle the beat is taken.
// Response channel (rsp_valid / rsp_stall): one beat per request, with
// rsp_hit, rsp_evicted_valid and rsp_evicted_key, the cycle after the request
// is taken. Throughput is one request per cycle while rsp_stall is low; the
// lookup, match chain through the slot cells and shift are combinational.
// When the receiver stalls, the response is held in its output register and
// req_stall is raised for as long as that beat is not taken.
// Configuration (csr_valid / csr_ready, csr_data): writes the capacity. Zero
// acts as one and values above the slot count saturate; lowering it below
// the number of keys held drops the least recent keys silently. csr_ready is
// always high; write only while no request is in flight.
// Reset (synchronous, active high) empties the store and sets the capacity
// to sixteen.
`default_nettype none

`include "lru_key_tracker_defines.svh"

module lru_key_tracker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [lkt_pkg::KEY_WIDTH-1:0] req_key,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_hit,
   output logic                               rsp_evicted_valid,
   output logic [lkt_pkg::KEY_WIDTH-1:0]      rsp_evicted_key,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lkt_pkg::CFG_W-1:0]     csr_data
);

   logic [lkt_pkg::CAP_W-1:0]     cap_ff;
   logic [lkt_pkg::CAP_W-1:0]     cap_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          hit_ff;
   logic                          ev_valid_ff;
   logic [lkt_pkg::KEY_WIDTH-1:0] ev_key_ff;
   logic                          fire;
   logic                          cfg_write;
   logic                          ev_valid;
   logic [lkt_pkg::ENTRIES-1:0]   vld;
   lkt_pkg::ctl_type              ctl;
   lkt_pkg::up_type               up_link   [lkt_pkg::ENTRIES+1];
   lkt_pkg::down_type             down_link [lkt_pkg::ENTRIES+1];

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   // Clamp the written capacity to one through the slot count.
   always_comb begin
      if (csr_data == '0) begin
         cap_in = lkt_pkg::CAP_W'(1);
      end else if (int'(csr_data) > lkt_pkg::ENTRIES) begin
         cap_in = lkt_pkg::CAP_W'(lkt_pkg::ENTRIES);
      end else begin
         cap_in = lkt_pkg::CAP_W'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkt_pkg::CAP_W'(lkt_pkg::CAP_RESET);
      end else if (cfg_write) begin
         cap_ff <= cap_in;
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;

   assign ctl.fire      = fire;
   assign ctl.key       = req_key;
   assign ctl.hit       = up_link[0].any_match;
   assign ctl.cap       = cap_ff;
   assign ctl.cfg_write = cfg_write;
   assign ctl.cfg_cap   = cap_in;

   assign up_link[lkt_pkg::ENTRIES] = '0;
   assign down_link[0].valid        = 1'b1;
   assign down_link[0].key          = req_key;

   for (genvar i = 0; i < lkt_pkg::ENTRIES; i++) begin : g_cell
      lkt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .slot     (lkt_pkg::CAP_W'(i)),
         .ctl      (ctl),
         .down_in  (down_link[i]),
         .down_out (down_link[i+1]),
         .up_in    (up_link[i+1]),
         .up_out   (up_link[i])
      );
      assign vld[i] = down_link[i+1].valid;
   end

   // A miss with the last allowed slot filled evicts that slot's key.
   assign ev_valid = !up_link[0].any_match && up_link[0].tail_valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         hit_ff      <= up_link[0].any_match;
         ev_valid_ff <= ev_valid;
         ev_key_ff   <= ev_valid ? up_link[0].tail_key : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_key   = ev_key_ff;

   `LKT_ASSERT(a_hit_no_evict, clock, reset, !(rsp_valid && hit_ff && ev_valid_ff), "hit evicts")
   `LKT_ASSERT(a_evict_key_zero, clock, reset, !rsp_valid || ev_valid_ff || ev_key_ff == '0, "stray key")
   `LKT_ASSERT(a_valid_prefix, clock, reset, ((vld + lkt_pkg::ENTRIES'(1)) & vld) == '0, "valid gap")
   `LKT_ASSERT(a_fill_in_cap, clock, reset, $countones(vld) <= int'(cap_ff), "over capacity")

endmodule

`default_nettype wire
